// ===== design/srf_pkg.sv =====
// ----------------------------------------------------------------------------
// srf_pkg: shared types and constants
// Register indexes, scale modes and fixed widths of the configuration port.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int UPSCALE_W   = 8;
  localparam int MODE_W      = 2;
  localparam int FIT_MIN_DEN = 100;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MAX_UPSCALE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SCALE_MODE  = cfg_idx_t'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LETTERBOX = 2'd0,
    MODE_FIT       = 2'd1,
    MODE_STRETCH   = 2'd2
  } scale_mode_t;

endpackage

// ===== design/srf_if.sv =====
// ----------------------------------------------------------------------------
// srf_if: channel interfaces
// Size input channel, rectangle result channel and register write channel.
// ----------------------------------------------------------------------------
interface srf_in_if #(parameter int DIM_BITS = 14);
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] panel_width;
  logic [DIM_BITS-1:0] panel_height;
  logic [DIM_BITS-1:0] source_width;
  logic [DIM_BITS-1:0] source_height;
  modport source (output valid, panel_width, panel_height, source_width, source_height,
                  input ready);
  modport sink (input valid, panel_width, panel_height, source_width, source_height,
                output ready);
endinterface

interface srf_out_if #(parameter int DIM_BITS = 14);
  logic                       valid;
  logic                       ready;
  logic signed [DIM_BITS-1:0] rect_x;
  logic signed [DIM_BITS-1:0] rect_y;
  logic        [DIM_BITS-1:0] rect_width;
  logic        [DIM_BITS-1:0] rect_height;
  modport source (output valid, rect_x, rect_y, rect_width, rect_height, input ready);
  modport sink (input valid, rect_x, rect_y, rect_width, rect_height, output ready);
endinterface

interface srf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [srf_pkg::CFG_IDX_W-1:0]  index;
  logic [srf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/srf_prep.sv =====
// ----------------------------------------------------------------------------
// srf_prep: dividend setup
// Picks the fit scale fraction, clamps it and builds the per-axis dividend
// and divisor; the other modes pass panel over source straight to the divider.
// ----------------------------------------------------------------------------
module srf_prep
  import srf_pkg::*;
#(
  parameter int D = 14,
  localparam int NW = 2*D+2,
  localparam int DW = D+1,
  localparam int SW = 4*D+1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [D-1:0]         pw,
  input  logic [D-1:0]         ph,
  input  logic [D-1:0]         sw,
  input  logic [D-1:0]         sh,
  input  logic [UPSCALE_W-1:0] max_upscale,
  input  logic [MODE_W-1:0]    scale_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SW-1:0]        out_side,
  output logic [1:0][NW-1:0]   out_num,
  output logic [1:0][DW-1:0]   out_div
);

  logic va_r, vb_r, vc_r, vd_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic [SW-1:0] side_a_r, side_b_r, side_c_r, side_d_r;
  logic [2*D-1:0] pa_r, pb_r;
  logic [D-1:0] num_b_r, den_b_r, num_c_r, den_c_r;
  logic [1:0][NW-1:0] num_d_r;
  logic [1:0][DW-1:0] div_d_r;

  logic sel, low, high;
  logic [D-1:0] num0, den0, num_b_nxt, den_b_nxt, num_c_nxt, den_c_nxt, mu;
  logic [D+7:0] prod_lo, prod_hi;
  logic [D-1:0] c_pw, c_ph, c_sw, c_sh;
  logic fit;
  logic [1:0][NW-1:0] num_d_nxt;
  logic [1:0][DW-1:0] div_d_nxt;

  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  // smaller of the two axis ratios, then the 1/100 floor
  always_comb begin
    sel       = pa_r <= pb_r;
    num0      = sel ? side_a_r[4*D-1:3*D] : side_a_r[3*D-1:2*D];
    den0      = sel ? side_a_r[2*D-1:D]   : side_a_r[D-1:0];
    prod_lo   = (D+8)'(num0) * (D+8)'(FIT_MIN_DEN);
    low       = prod_lo < (D+8)'(den0);
    num_b_nxt = low ? D'(1) : num0;
    den_b_nxt = low ? D'(FIT_MIN_DEN) : den0;
  end

  // upscale cap
  always_comb begin
    mu        = D'(max_upscale);
    prod_hi   = (D+8)'(mu) * (D+8)'(den_b_r);
    high      = (mu != '0) && ((D+8)'(num_b_r) > prod_hi);
    num_c_nxt = high ? mu : num_b_r;
    den_c_nxt = high ? D'(1) : den_b_r;
  end

  // dividend 2*src*num + den over 2*den, or panel over source
  always_comb begin
    c_pw = side_c_r[4*D-1:3*D];
    c_ph = side_c_r[3*D-1:2*D];
    c_sw = side_c_r[2*D-1:D];
    c_sh = side_c_r[D-1:0];
    fit  = scale_mode == MODE_FIT;
    if (fit) begin
      num_d_nxt[0] = NW'({c_sw, 1'b0}) * NW'(num_c_r) + NW'(den_c_r);
      num_d_nxt[1] = NW'({c_sh, 1'b0}) * NW'(num_c_r) + NW'(den_c_r);
      div_d_nxt[0] = {den_c_r, 1'b0};
      div_d_nxt[1] = {den_c_r, 1'b0};
    end else begin
      num_d_nxt[0] = NW'(c_pw);
      num_d_nxt[1] = NW'(c_ph);
      div_d_nxt[0] = DW'(c_sw);
      div_d_nxt[1] = DW'(c_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      side_a_r <= {(pw == '0) || (ph == '0) || (sw == '0) || (sh == '0), pw, ph, sw, sh};
      pa_r     <= (2*D)'(pw) * (2*D)'(sh);
      pb_r     <= (2*D)'(ph) * (2*D)'(sw);
    end
    if (rdy_b && va_r) begin
      side_b_r <= side_a_r;
      num_b_r  <= num_b_nxt;
      den_b_r  <= den_b_nxt;
    end
    if (rdy_c && vb_r) begin
      side_c_r <= side_b_r;
      num_c_r  <= num_c_nxt;
      den_c_r  <= den_c_nxt;
    end
    if (rdy_d && vc_r) begin
      side_d_r <= side_c_r;
      num_d_r  <= num_d_nxt;
      div_d_r  <= div_d_nxt;
    end
  end

  assign out_valid = vd_r;
  assign out_side  = side_d_r;
  assign out_num   = num_d_r;
  assign out_div   = div_d_r;

endmodule

// ===== design/srf_div_cell.sv =====
// ----------------------------------------------------------------------------
// srf_div_cell: one restoring division step
// Takes one dividend bit into the partial remainder for both axes and
// shifts one quotient bit in; a row of these forms the divider.
// ----------------------------------------------------------------------------
module srf_div_cell #(
  parameter int NW = 30,
  parameter int DW = 15,
  parameter int SW = 57
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SW-1:0]      in_side,
  input  logic [1:0][DW-1:0] in_rem,
  input  logic [1:0][NW-1:0] in_num,
  input  logic [1:0][NW-1:0] in_quo,
  input  logic [1:0][DW-1:0] in_div,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SW-1:0]      out_side,
  output logic [1:0][DW-1:0] out_rem,
  output logic [1:0][NW-1:0] out_num,
  output logic [1:0][NW-1:0] out_quo,
  output logic [1:0][DW-1:0] out_div
);

  logic               valid_r;
  logic [SW-1:0]      side_r;
  logic [1:0][DW-1:0] rem_r, div_r, rem_nxt;
  logic [1:0][NW-1:0] num_r, quo_r, num_nxt, quo_nxt;
  logic [1:0][DW:0]   trial, diff;
  logic [1:0]         ge;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l]   = {in_rem[l], in_num[l][NW-1]};
      diff[l]    = trial[l] - {1'b0, in_div[l]};
      ge[l]      = trial[l] >= {1'b0, in_div[l]};
      rem_nxt[l] = ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
      num_nxt[l] = {in_num[l][NW-2:0], 1'b0};
      quo_nxt[l] = {in_quo[l][NW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      side_r <= in_side;
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      quo_r  <= quo_nxt;
      div_r  <= in_div;
    end
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;
  assign out_rem   = rem_r;
  assign out_num   = num_r;
  assign out_quo   = quo_r;
  assign out_div   = div_r;

endmodule

// ===== design/srf_post.sv =====
// ----------------------------------------------------------------------------
// srf_post: scale finish and placement
// Letterbox scale pick and multiply, fit size pass-through, stretch and
// zero-size cases, centering offsets and the output register.
// ----------------------------------------------------------------------------
module srf_post
  import srf_pkg::*;
#(
  parameter int D = 14,
  localparam int NW = 2*D+2,
  localparam int SW = 4*D+1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SW-1:0]        in_side,
  input  logic [1:0][NW-1:0]   in_quo,
  input  logic [UPSCALE_W-1:0] max_upscale,
  input  logic [MODE_W-1:0]    scale_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [D-1:0]  rect_x,
  output logic signed [D-1:0]  rect_y,
  output logic [D-1:0]         rect_width,
  output logic [D-1:0]         rect_height
);

  function automatic logic [D-1:0] half_off(input logic [D-1:0] p, input logic [NW-1:0] s);
    logic signed [NW:0] d;
    logic signed [NW:0] h;
    d = $signed({1'b0, NW'(p)}) - $signed({1'b0, s});
    h = d >>> 1;
    // round toward zero for negative odd differences
    if (d[NW] && d[0]) h = h + 1'b1;
    return h[D-1:0];
  endfunction

  logic v1_r, v2_r, vo_r;
  logic rdy1, rdy2, rdyo;
  logic [SW-1:0] side1_r, side2_r;
  logic [1:0][NW-1:0] quo1_r, size2_r, size2_nxt;
  logic [D-1:0] s_r, s_min, s_one, s_nxt, mu;
  logic signed [D-1:0] x_nxt, y_nxt, x_r, y_r;
  logic [D-1:0] w_nxt, h_nxt, w_r, h_r;

  assign rdyo     = !vo_r || out_ready;
  assign rdy2     = !v2_r || rdyo;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    mu    = D'(max_upscale);
    s_min = (in_quo[0][D-1:0] < in_quo[1][D-1:0]) ? in_quo[0][D-1:0] : in_quo[1][D-1:0];
    s_one = (s_min == '0) ? D'(1) : s_min;
    s_nxt = ((mu != '0) && (s_one > mu)) ? mu : s_one;
  end

  always_comb begin
    if (scale_mode == MODE_FIT) begin
      size2_nxt = quo1_r;
    end else begin
      size2_nxt[0] = NW'(side1_r[2*D-1:D]) * NW'(s_r);
      size2_nxt[1] = NW'(side1_r[D-1:0]) * NW'(s_r);
    end
  end

  always_comb begin
    if (side2_r[SW-1]) begin
      x_nxt = '0;
      y_nxt = '0;
      w_nxt = side2_r[2*D-1:D];
      h_nxt = side2_r[D-1:0];
    end else if (scale_mode == MODE_STRETCH) begin
      x_nxt = '0;
      y_nxt = '0;
      w_nxt = side2_r[4*D-1:3*D];
      h_nxt = side2_r[3*D-1:2*D];
    end else begin
      x_nxt = $signed(half_off(side2_r[4*D-1:3*D], size2_r[0]));
      y_nxt = $signed(half_off(side2_r[3*D-1:2*D], size2_r[1]));
      w_nxt = size2_r[0][D-1:0];
      h_nxt = size2_r[1][D-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdyo) vo_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      side1_r <= in_side;
      quo1_r  <= in_quo;
      s_r     <= s_nxt;
    end
    if (rdy2 && v1_r) begin
      side2_r <= side1_r;
      size2_r <= size2_nxt;
    end
    if (rdyo && v2_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      w_r <= w_nxt;
      h_r <= h_nxt;
    end
  end

  assign out_valid   = vo_r;
  assign rect_x      = x_r;
  assign rect_y      = y_r;
  assign rect_width  = w_r;
  assign rect_height = h_r;

endmodule

// ===== design/scaled_rectangle_fit.sv =====
// ----------------------------------------------------------------------------
// scaled_rectangle_fit: centered target rectangle for a source in a panel
// Each beat on in_bus carries a panel size and a source size; one beat on
// out_bus returns the origin and size of the scaled, centered image.
// Registers on cfg_bus: index 0 max_upscale (0 = unlimited), index 1
// scale_mode (0 letterbox, 1 fit, 2 stretch, 3 as letterbox). cfg_bus is
// always ready; write only while no item is in flight.
// The pipeline holds four setup stages, a row of 2*DIM_BITS+2 restoring
// division cells (one quotient bit per cell, both axes side by side), two
// finishing stages and the output register.
// Throughput is one item per cycle; every stage holds its own valid bit, so
// the row keeps filling bubbles and accepting beats while a result waits.
// When out_bus stalls and all stages are full, in_bus ready drops.
// Reset clears all valid bits and sets both registers to zero.
// ----------------------------------------------------------------------------
module scaled_rectangle_fit
  import srf_pkg::*;
#(
  parameter int DIM_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  srf_in_if.sink             in_bus,
  srf_out_if.source          out_bus,
  srf_cfg_if.sink            cfg_bus
);

  localparam int NW = 2*DIM_BITS+2;
  localparam int DW = DIM_BITS+1;
  localparam int SW = 4*DIM_BITS+1;

  logic [UPSCALE_W-1:0] mu_r;
  logic [MODE_W-1:0]    mode_r;

  logic               c_valid [NW+1];
  logic               c_ready [NW+1];
  logic [SW-1:0]      c_side  [NW+1];
  logic [1:0][DW-1:0] c_rem   [NW+1];
  logic [1:0][NW-1:0] c_num   [NW+1];
  logic [1:0][NW-1:0] c_quo   [NW+1];
  logic [1:0][DW-1:0] c_div   [NW+1];

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r   <= '0;
      mode_r <= MODE_LETTERBOX;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_MAX_UPSCALE: mu_r   <= cfg_bus.data[UPSCALE_W-1:0];
        REG_SCALE_MODE:  mode_r <= cfg_bus.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  srf_prep #(.D(DIM_BITS)) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .pw          (in_bus.panel_width),
    .ph          (in_bus.panel_height),
    .sw          (in_bus.source_width),
    .sh          (in_bus.source_height),
    .max_upscale (mu_r),
    .scale_mode  (mode_r),
    .out_valid   (c_valid[0]),
    .out_ready   (c_ready[0]),
    .out_side    (c_side[0]),
    .out_num     (c_num[0]),
    .out_div     (c_div[0])
  );

  assign c_rem[0] = '0;
  assign c_quo[0] = '0;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    srf_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .in_side   (c_side[k]),
      .in_rem    (c_rem[k]),
      .in_num    (c_num[k]),
      .in_quo    (c_quo[k]),
      .in_div    (c_div[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .out_side  (c_side[k+1]),
      .out_rem   (c_rem[k+1]),
      .out_num   (c_num[k+1]),
      .out_quo   (c_quo[k+1]),
      .out_div   (c_div[k+1])
    );
  end

  srf_post #(.D(DIM_BITS)) u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (c_valid[NW]),
    .in_ready    (c_ready[NW]),
    .in_side     (c_side[NW]),
    .in_quo      (c_quo[NW]),
    .max_upscale (mu_r),
    .scale_mode  (mode_r),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .rect_x      (out_bus.rect_x),
    .rect_y      (out_bus.rect_y),
    .rect_width  (out_bus.rect_width),
    .rect_height (out_bus.rect_height)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_bus.valid)
    else $error("result valid after reset");
  a_backpressure_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (out_bus.valid && !out_bus.ready))
    else $error("input stalled without a blocked result");
  a_drop_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_bus.valid) |-> $past(out_bus.ready))
    else $error("result dropped before it was taken");
  a_first_cell_gated: assert property (@(posedge clk) disable iff (!rst_n)
    !c_ready[0] |-> c_valid[1])
    else $error("empty first cell blocked");
`endif

endmodule

// ===== dv/srf_checker.sv =====
// ----------------------------------------------------------------------------
// srf_checker: rectangle predictor and result comparison
// Watches the size, result and register channels, computes the expected
// rectangle for every accepted size beat and compares result beats in order.
// ----------------------------------------------------------------------------
module srf_checker
  import srf_pkg::*;
#(
  parameter int DIM_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  srf_in_if.sink    in_mon,
  srf_out_if.sink   out_mon,
  srf_cfg_if.sink   cfg_mon,
  output int        fail_count,
  output int        pending_rects
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DIM_BITS-1:0] x;
    logic signed [DIM_BITS-1:0] y;
    logic        [DIM_BITS-1:0] w;
    logic        [DIM_BITS-1:0] h;
  } rect_t;

  rect_t                expected_rects[$];
  logic [UPSCALE_W-1:0] upscale_cap;
  scale_mode_t          mode_sel;

  function automatic logic [DIM_BITS-1:0] center_offset(longint panel, longint size);
    longint diff;
    diff = panel - size;
    return DIM_BITS'(diff / 2);
  endfunction

  function automatic rect_t place_rect(longint pw, longint ph, longint sw, longint sh);
    rect_t  r;
    longint num, den, w, h, sx, sy, s;
    if (pw == 0 || ph == 0 || sw == 0 || sh == 0) begin
      r.x = '0;
      r.y = '0;
      r.w = DIM_BITS'(sw);
      r.h = DIM_BITS'(sh);
      return r;
    end
    if (mode_sel == MODE_STRETCH) begin
      r.x = '0;
      r.y = '0;
      r.w = DIM_BITS'(pw);
      r.h = DIM_BITS'(ph);
      return r;
    end
    if (mode_sel == MODE_FIT) begin
      // smaller of the two axis ratios, compared by cross products
      if (pw * sh <= ph * sw) begin
        num = pw;
        den = sw;
      end else begin
        num = ph;
        den = sh;
      end
      if (num * FIT_MIN_DEN < den) begin
        num = 1;
        den = FIT_MIN_DEN;
      end
      if (upscale_cap != 0 && num > longint'(upscale_cap) * den) begin
        num = upscale_cap;
        den = 1;
      end
      w = (2 * sw * num + den) / (2 * den);
      h = (2 * sh * num + den) / (2 * den);
    end else begin
      // letterbox, also taken by the unused mode code
      sx = pw / sw;
      sy = ph / sh;
      s  = (sx < sy) ? sx : sy;
      if (s < 1) s = 1;
      if (upscale_cap != 0 && s > upscale_cap) s = upscale_cap;
      w = sw * s;
      h = sh * s;
    end
    r.x = center_offset(pw, w);
    r.y = center_offset(ph, h);
    r.w = DIM_BITS'(w);
    r.h = DIM_BITS'(h);
    return r;
  endfunction

  always @(posedge clk) begin
    rect_t got, want;
    if (!rst_n) begin
      upscale_cap <= '0;
      mode_sel    <= MODE_LETTERBOX;
      fail_count  <= 0;
      expected_rects.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_MAX_UPSCALE) upscale_cap <= cfg_mon.data;
        else if (cfg_mon.index == REG_SCALE_MODE) mode_sel <= scale_mode_t'(cfg_mon.data[MODE_W-1:0]);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.rect_x, out_mon.rect_y, out_mon.rect_width, out_mon.rect_height};
        if (expected_rects.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected result beat x=%0d y=%0d w=%0d h=%0d",
                     got.x, got.y, got.w, got.h);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rects.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("ERROR: rect mismatch exp x=%0d y=%0d w=%0d h=%0d got x=%0d y=%0d w=%0d h=%0d",
                       want.x, want.y, want.w, want.h, got.x, got.y, got.w, got.h);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_rects.push_back(place_rect(in_mon.panel_width, in_mon.panel_height,
                                            in_mon.source_width, in_mon.source_height));
    end
    pending_rects <= expected_rects.size();
  end

endmodule

// ===== dv/scaled_rectangle_fit_tb.sv =====
// ----------------------------------------------------------------------------
// scaled_rectangle_fit_tb: stimulus and verdict
// Drives size beats through several register settings with random gaps and
// result stalls; the checker predicts and compares every rectangle.
// ----------------------------------------------------------------------------
module scaled_rectangle_fit_tb
  import srf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_BITS = 14;
  localparam int LATENCY  = 2 * DIM_BITS + 9;
  localparam int DIM_MAX  = (1 << DIM_BITS) - 1;
  localparam longint CYCLE_LIMIT = 400000;
  // no register lives at this index
  localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(7);
  // mode code with no mode of its own
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  int     fail_count;
  int     pending_rects;
  longint cycle_count = 0;

  srf_in_if  #(DIM_BITS) in_bus();
  srf_out_if #(DIM_BITS) out_bus();
  srf_cfg_if             cfg_bus();

  scaled_rectangle_fit #(.DIM_BITS(DIM_BITS)) DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  srf_checker #(.DIM_BITS(DIM_BITS)) u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_bus), .out_mon(out_bus), .cfg_mon(cfg_bus),
    .fail_count(fail_count), .pending_rects(pending_rects)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // result side stalls at random, with calm stretches
  initial begin
    out_bus.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk iff cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_pipe();
    @(posedge clk iff pending_rects == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_sizes(int pw, int ph, int sw, int sh);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.panel_width   <= DIM_BITS'(pw);
    in_bus.panel_height  <= DIM_BITS'(ph);
    in_bus.source_width  <= DIM_BITS'(sw);
    in_bus.source_height <= DIM_BITS'(sh);
    @(posedge clk iff in_bus.ready);
  endtask

  function automatic int rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)  return 0;
    if (r < 8)  return DIM_MAX;
    if (r < 40) return $urandom_range(1, 64);
    if (r < 75) return $urandom_range(1, 2048);
    return $urandom_range(1, DIM_MAX);
  endfunction

  task automatic run_phase(scale_mode_t mode_code, logic [1:0] raw_mode,
                           logic [7:0] cap, int count);
    drain_pipe();
    write_reg(REG_MAX_UPSCALE, cap);
    write_reg(REG_SCALE_MODE, {6'd0, raw_mode});
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0 && mode_code == MODE_LETTERBOX)
        send_sizes($urandom_range(1, 16383), $urandom_range(1, 16383),
                   $urandom_range(1, 400), $urandom_range(1, 400));
      else
        send_sizes(rand_dim(), rand_dim(), rand_dim(), rand_dim());
    end
    in_bus.valid <= 1'b0;
  endtask

  initial begin
    in_bus.valid         = 1'b0;
    in_bus.panel_width   = '0;
    in_bus.panel_height  = '0;
    in_bus.source_width  = '0;
    in_bus.source_height = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then each mode with edge sizes
    send_sizes(1920, 1080, 640, 480);
    send_sizes(0, 1080, 640, 480);
    send_sizes(1920, 1080, 0, 0);
    send_sizes(100, 100, 300, 50);
    send_sizes(DIM_MAX, DIM_MAX, 1, 1);
    in_bus.valid <= 1'b0;
    drain_pipe();
    write_reg(REG_UNUSED, 8'hff);
    write_reg(REG_MAX_UPSCALE, 8'd3);
    send_sizes(DIM_MAX, DIM_MAX, 1, 1);
    send_sizes(800, 600, 320, 200);
    in_bus.valid <= 1'b0;
    drain_pipe();
    write_reg(REG_SCALE_MODE, {6'd0, MODE_FIT});
    send_sizes(DIM_MAX, DIM_MAX, 1, 1);
    send_sizes(1, 1, DIM_MAX, DIM_MAX);
    send_sizes(1920, 1080, 640, 480);
    send_sizes(3, 5, 2, 2);
    send_sizes(100, 7, 300, 50);
    send_sizes(DIM_MAX, 1, 1, DIM_MAX);
    in_bus.valid <= 1'b0;
    drain_pipe();
    write_reg(REG_SCALE_MODE, {6'd0, MODE_STRETCH});
    send_sizes(1, DIM_MAX, 640, 480);
    send_sizes(DIM_MAX, 0, 640, 480);
    in_bus.valid <= 1'b0;

    run_phase(MODE_LETTERBOX, MODE_LETTERBOX, 8'd0, 150);
    run_phase(MODE_FIT, MODE_FIT, 8'd0, 200);
    run_phase(MODE_FIT, MODE_FIT, 8'd255, 100);
    run_phase(MODE_FIT, MODE_FIT, 8'd1, 100);
    run_phase(MODE_LETTERBOX, MODE_LETTERBOX, 8'd255, 100);
    run_phase(MODE_LETTERBOX, MODE_UNUSED, 8'd2, 100);
    run_phase(MODE_STRETCH, MODE_STRETCH, 8'd5, 60);
    run_phase(MODE_FIT, MODE_FIT, 8'($urandom_range(1, 254)), 150);

    drain_pipe();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
